[rtl/core/wmmm_pkg.sv]
`default_nettype none

package wmmm_pkg;

  localparam int DATA_W          = 16;
  localparam int CFG_W           = 8;
  localparam int MAX_WINDOW_DEF  = 128;
  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 8'd128;

  // Per-cycle control from the sequencer to the statistics unit.
  typedef struct packed {
    logic clr;
    logic take;
  } scan_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_LOAD = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_PUSH = 5'b10000
  } state_e;

endpackage

`default_nettype wire

[rtl/core/wmmm_cell.sv]
`default_nettype none

module wmmm_cell
  import wmmm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_i,
  input  wire logic [DATA_W-1:0] d_i,
  output logic      [DATA_W-1:0] q_o
);

  logic [DATA_W-1:0] slot_q, slot_d;

  always_comb begin
    slot_d = shift_i ? d_i : slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign q_o = slot_q;

endmodule

`default_nettype wire

[rtl/core/wmmm_accum.sv]
`default_nettype none

module wmmm_accum
  import wmmm_pkg::*;
#(
  parameter int SUM_W = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire scan_ctl_t                ctl_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic signed      [SUM_W-1:0]  sum_o,
  output logic signed      [DATA_W-1:0] min_o,
  output logic signed      [DATA_W-1:0] max_o
);

  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [DATA_W-1:0] min_q, min_d, max_q, max_d;

  always_comb begin
    sum_d = sum_q;
    min_d = min_q;
    max_d = max_q;
    if (ctl_i.clr) begin
      sum_d = '0;
      min_d = {1'b0, {(DATA_W-1){1'b1}}};
      max_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (ctl_i.take) begin
      sum_d = sum_q + SUM_W'(value_i);
      if (value_i < min_q) min_d = value_i;
      if (value_i > max_q) max_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      min_q <= '0;
      max_q <= '0;
    end else begin
      sum_q <= sum_d;
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign sum_o = sum_q;
  assign min_o = min_q;
  assign max_o = max_q;

endmodule

`default_nettype wire

[rtl/core/wmmm_div.sv]
`default_nettype none

module wmmm_div
  import wmmm_pkg::*;
#(
  parameter int SUM_W = 24,
  parameter int LEN_W = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  input  wire logic        [LEN_W-1:0] divisor_i,
  output logic                         done_o,
  output logic signed      [DATA_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] quo_q, quo_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;
  logic [LEN_W:0]   trial;
  logic [SUM_W-1:0] quo_signed;

  // Restoring division on the magnitude, one quotient bit per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[SUM_W-1]};
    if (start_i) begin
      quo_d  = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      neg_d  = dividend_i[SUM_W-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = LEN_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[LEN_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign quo_signed = neg_q ? SUM_W'(-quo_q) : quo_q;
  assign quot_o     = quo_signed[DATA_W-1:0];
  assign done_o     = done_q;

endmodule

`default_nettype wire

[rtl/core/window_mean_min_max_top.sv]
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: sample[15:0]
// m_axis    out        tdata: mean_value[15:0], minimum_value[31:16], maximum_value[47:32]
// cfg       in         cfg_data: window_size[7:0]
//
// For each item the slot ring makes one full turn past its head cell, then the sequential
// divider produces one quotient bit per cycle over the SUM_W-bit window sum.
// Reset clears every slot and the write position and sets the window size to 128 at once.
// A new item is taken while the previous result still waits in the output register;
// the finished result is held until that register is free.
`default_nettype none

module window_mean_min_max_top
  import wmmm_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [DATA_W-1:0]   s_axis_tdata_i,   // sample
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [3*DATA_W-1:0] m_axis_tdata_o,   // mean_value, minimum_value, maximum_value
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CFG_W-1:0]    cfg_data_i
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = DATA_W + LEN_W;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  wsize_q, wsize_d;
  logic [IDX_W-1:0]  wpos_q, wpos_d;
  logic [IDX_W-1:0]  widx_q, widx_d;
  logic [IDX_W-1:0]  step_q, step_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [DATA_W-1:0] sample_q, sample_d;
  logic              ovld_q, ovld_d;
  logic [3*DATA_W-1:0] odata_q, odata_d;

  logic [LEN_W-1:0]  len_now;
  logic [IDX_W-1:0]  wr_eff;
  logic [LEN_W:0]    wr_next;
  logic              in_acc, last_step, shift, out_load;
  logic [DATA_W-1:0] head_val;
  logic [DATA_W-1:0] slot [MAX_WINDOW];

  scan_ctl_t               scan_ctl;
  logic signed [SUM_W-1:0]  win_sum;
  logic signed [DATA_W-1:0] win_min, win_max, win_mean;
  logic                     div_done;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign last_step       = (step_q == IDX_W'(MAX_WINDOW - 1));
  assign shift           = (state_q == ST_SCAN);

  // Effective window length and the slot this item overwrites.
  always_comb begin
    if (wsize_q == '0) begin
      len_now = LEN_W'(1);
    end else if (wsize_q > CFG_W'(MAX_WINDOW)) begin
      len_now = LEN_W'(MAX_WINDOW);
    end else begin
      len_now = LEN_W'(wsize_q);
    end
    wr_eff  = (LEN_W'(wpos_q) >= len_now) ? '0 : wpos_q;
    wr_next = (LEN_W+1)'(wr_eff) + 1'b1;
  end

  // Slot k passes the head cell at scan step k; the new sample replaces it there.
  assign head_val = (step_q == widx_q) ? sample_q : slot[0];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [DATA_W-1:0] nb;
    if (i == MAX_WINDOW - 1) begin : g_tail
      assign nb = head_val;
    end else begin : g_mid
      assign nb = slot[i+1];
    end
    wmmm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (nb),
      .q_o     (slot[i])
    );
  end

  assign scan_ctl.clr  = in_acc;
  assign scan_ctl.take = shift && (LEN_W'(step_q) < len_q);

  wmmm_accum #(.SUM_W(SUM_W)) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .value_i (head_val),
    .sum_o   (win_sum),
    .min_o   (win_min),
    .max_o   (win_max)
  );

  wmmm_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_LOAD),
    .dividend_i (win_sum),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quot_o     (win_mean)
  );

  always_comb begin
    state_d  = state_q;
    wsize_d  = wsize_q;
    wpos_d   = wpos_q;
    widx_d   = widx_q;
    step_d   = step_q;
    len_d    = len_q;
    sample_d = sample_q;
    out_load = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      wsize_d = cfg_data_i;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          sample_d = s_axis_tdata_i;
          len_d    = len_now;
          widx_d   = wr_eff;
          wpos_d   = (wr_next >= (LEN_W+1)'(len_now)) ? '0 : wr_next[IDX_W-1:0];
          step_d   = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        step_d = last_step ? '0 : step_q + 1'b1;
        if (last_step) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!ovld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    odata_d = odata_q;
    ovld_d  = ovld_q;
    if (out_load) begin
      odata_d = {win_max, win_min, win_mean};
      ovld_d  = 1'b1;
    end else if (m_axis_tready_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wsize_q <= WINDOW_SIZE_RST;
      wpos_q  <= '0;
      step_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wsize_q <= wsize_d;
      wpos_q  <= wpos_d;
      step_q  <= step_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q   <= widx_d;
    len_q    <= len_d;
    sample_q <= sample_d;
    odata_q  <= odata_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

`default_nettype wire

[rtl/core/wmmm_checker.sv]
`default_nettype none

module wmmm_checker
  import wmmm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid_i,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [3*DATA_W-1:0] m_axis_tdata_o
);

  logic signed [DATA_W-1:0] mean_v, min_v, max_v;

  assign mean_v = m_axis_tdata_o[DATA_W-1:0];
  assign min_v  = m_axis_tdata_o[2*DATA_W-1:DATA_W];
  assign max_v  = m_axis_tdata_o[3*DATA_W-1:2*DATA_W];

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // An accepted item keeps the block busy for the following cycle.
  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after an accepted item");

  // A new result only appears out of a busy period.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result appeared while idle");

  // The truncated mean lies between the window extremes.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (min_v <= mean_v) && (mean_v <= max_v))
    else $error("minimum, mean and maximum out of order");

endmodule

bind window_mean_min_max_top wmmm_checker u_wmmm_checker (.*);

`default_nettype wire
